>>> design/rtpfu_pkg.sv
package rtpfu_pkg;

	// 90 kHz media clock, capture time in microseconds.
	localparam int CLOCK_RATE_HZ = 90000;
	localparam int RATE_W        = $clog2(CLOCK_RATE_HZ + 1);
	localparam int PROD_W        = 32 + RATE_W;
	localparam int US_PER_SEC    = 1000000;
	localparam logic [63:0] ROUND_BIAS = 64'(US_PER_SEC / 2);

	// One million is 2^6 times an odd factor; the shift is free, the odd factor
	// is divided out 16 quotient bits at a time by a reciprocal multiply.
	localparam int DIV_SHIFT   = 6;
	localparam int DIV_ODD     = US_PER_SEC >> DIV_SHIFT;
	localparam int DIG_W       = 16;
	localparam int REM_W       = $clog2(DIV_ODD);
	localparam int V_W         = REM_W + DIG_W;
	localparam int RECIP_SHIFT = 44;
	localparam int RECIP_W     = 31;
	localparam logic [RECIP_W-1:0] RECIP_MUL =
		RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(DIV_ODD));
	localparam int MQ_W        = V_W + RECIP_W;
	localparam int TS_STAGES   = 12;

	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [10:0] MAX_PAYLOAD_RST = 11'd1200;
	localparam logic [7:0]  NRI_MASK        = 8'h60;
	localparam logic [7:0]  TYPE_MASK       = 8'h1f;
	localparam logic [7:0]  FU_A_TYPE       = 8'd28;
	localparam logic [7:0]  FU_START        = 8'h80;
	localparam logic [7:0]  FU_END          = 8'h40;
	localparam logic [5:0]  END_HINT_VAL    = 6'd33;

	typedef enum logic [2:0] {
		CFG_MAX_PAYLOAD   = 3'd0,
		CFG_PAYLOAD_TYPE  = 3'd1,
		CFG_SSRC          = 3'd2,
		CFG_FIRST_RTP_SEQ = 3'd3,
		CFG_FIRST_TSEQ    = 3'd4,
		CFG_BASE_TS       = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic [7:0]         nal_byte;
		logic [15:0]        nal_length;
		logic               unit_last_nal;
		logic signed [63:0] capture_us;
		logic [1:0]         frame_kind;
	} nal_item_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		logic               packet_first;
		logic               packet_last;
		logic               run_last;
		logic               marker_bit;
		logic [15:0]        rtp_seq;
		logic [15:0]        transport_seq;
		logic [31:0]        stamp_90k;
		logic signed [63:0] capture_time_out;
		logic [1:0]         frame_kind_out;
		logic [5:0]         end_hint;
	} pkt_item_t;

	typedef struct packed {
		nal_item_t   item;
		logic [31:0] ts;
	} q_entry_t;

	typedef struct packed {
		logic        rtp_ld;
		logic        tseq_ld;
		logic [15:0] value;
	} seq_load_t;

endpackage

>>> design/rtpfu_ts90k.sv
module rtpfu_ts90k (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  rtpfu_pkg::nal_item_t  in_item,
	input  logic [31:0]           base_ts,
	output logic                  out_vld,
	output rtpfu_pkg::q_entry_t   out_entry
);
	import rtpfu_pkg::*;

	logic [PROD_W-1:0] lo_prod;
	logic [31:0]       hi_prod;

	logic              vld_sh [TS_STAGES];
	nal_item_t         item_sh [TS_STAGES];

	logic [PROD_W-1:0] lo_s1;
	logic [31:0]       hi_s1;
	logic [63:0]       x_s2;
	logic [31:0]       yl_s3, yl_s4, yl_s5, yl_s6, yl_s7, yl_s8;
	logic [V_W-1:0]    v1_s3, v2_s6, v3_s9;
	logic [MQ_W-1:0]   m1_s3, m2_s6, m3_s9;
	logic [REM_W:0]    rp1_s4, rp2_s7, rp3_s10;
	logic [DIG_W-1:0]  q2e_s7, q3e_s10;
	logic [REM_W-1:0]  r1_s5, r2_s8;
	logic [DIG_W-1:0]  q2_s8, q2_s9, q2_s10, q2_s11, q3_s11;
	logic [31:0]       ts_s12;

	logic [V_W-1:0]    v1, v2, v3;
	logic [DIG_W-1:0]  qe1, qe2, qe3;
	logic              positive;

	// The capture time times the clock rate, modulo 2^64, from two 32-bit halves.
	assign lo_prod = PROD_W'(in_item.capture_us[31:0]) * PROD_W'(CLOCK_RATE_HZ);
	assign hi_prod = in_item.capture_us[63:32] * 32'(CLOCK_RATE_HZ);

	// Dividend for each digit: previous remainder followed by the next 16 bits of
	// x >> 6. The top ten bits are already below the divisor.
	assign v1 = V_W'({x_s2[63:54], x_s2[53:38]});
	assign v2 = {r1_s5, yl_s5[31:16]};
	assign v3 = {r2_s8, yl_s8[15:0]};

	assign qe1 = m1_s3[RECIP_SHIFT +: DIG_W];
	assign qe2 = m2_s6[RECIP_SHIFT +: DIG_W];
	assign qe3 = m3_s9[RECIP_SHIFT +: DIG_W];

	assign positive = (item_sh[TS_STAGES-2].capture_us != 64'sd0) &&
		!item_sh[TS_STAGES-2].capture_us[63];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TS_STAGES; k++) begin
				vld_sh[k] <= 1'b0;
			end
		end else begin
			vld_sh[0] <= in_vld;
			for (int k = 1; k < TS_STAGES; k++) begin
				vld_sh[k] <= vld_sh[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		item_sh[0] <= in_item;
		for (int k = 1; k < TS_STAGES; k++) begin
			item_sh[k] <= item_sh[k-1];
		end

		lo_s1 <= lo_prod;
		hi_s1 <= hi_prod;
		x_s2  <= 64'(lo_s1) + {hi_s1, 32'd0} + ROUND_BIAS;

		// First digit: only its remainder matters.
		yl_s3  <= x_s2[37:6];
		v1_s3  <= v1;
		m1_s3  <= MQ_W'(v1) * MQ_W'(RECIP_MUL);
		yl_s4  <= yl_s3;
		rp1_s4 <= (REM_W+1)'(v1_s3 - V_W'(qe1) * V_W'(DIV_ODD));
		yl_s5  <= yl_s4;
		r1_s5  <= (rp1_s4 >= (REM_W+1)'(DIV_ODD)) ?
			REM_W'(rp1_s4 - (REM_W+1)'(DIV_ODD)) : REM_W'(rp1_s4);

		// Second digit gives quotient bits 31:16.
		yl_s6  <= yl_s5;
		v2_s6  <= v2;
		m2_s6  <= MQ_W'(v2) * MQ_W'(RECIP_MUL);
		yl_s7  <= yl_s6;
		q2e_s7 <= qe2;
		rp2_s7 <= (REM_W+1)'(v2_s6 - V_W'(qe2) * V_W'(DIV_ODD));
		yl_s8  <= yl_s7;
		if (rp2_s7 >= (REM_W+1)'(DIV_ODD)) begin
			r2_s8 <= REM_W'(rp2_s7 - (REM_W+1)'(DIV_ODD));
			q2_s8 <= q2e_s7 + DIG_W'(1);
		end else begin
			r2_s8 <= REM_W'(rp2_s7);
			q2_s8 <= q2e_s7;
		end

		// Third digit gives quotient bits 15:0.
		v3_s9   <= v3;
		m3_s9   <= MQ_W'(v3) * MQ_W'(RECIP_MUL);
		q2_s9   <= q2_s8;
		q3e_s10 <= qe3;
		rp3_s10 <= (REM_W+1)'(v3_s9 - V_W'(qe3) * V_W'(DIV_ODD));
		q2_s10  <= q2_s9;
		q3_s11  <= (rp3_s10 >= (REM_W+1)'(DIV_ODD)) ? q3e_s10 + DIG_W'(1) : q3e_s10;
		q2_s11  <= q2_s10;

		ts_s12 <= positive ? base_ts + {q2_s11, q3_s11} : base_ts;
	end

	assign out_vld        = vld_sh[TS_STAGES-1];
	assign out_entry.item = item_sh[TS_STAGES-1];
	assign out_entry.ts   = ts_s12;

endmodule

>>> design/rtpfu_front.sv
module rtpfu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 nal_valid,
	output logic                 nal_ready,
	input  rtpfu_pkg::nal_item_t nal_data,
	input  logic                 pop,
	input  logic [31:0]          base_ts,
	output logic                 push,
	output rtpfu_pkg::q_entry_t  push_entry
);
	import rtpfu_pkg::*;

	logic [QCNT_W-1:0] reserved_q;
	logic              accept;
	nal_item_t         norm;

	// Every accepted byte holds a queue slot from acceptance until the back end
	// retires it, so the timestamp pipeline never has to stall.
	assign nal_ready = reserved_q < QCNT_W'(QUEUE_DEPTH);
	assign accept    = nal_valid && nal_ready;

	always_comb begin
		norm = nal_data;
		if (nal_data.nal_length == 16'd0) begin
			norm.nal_length = 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else begin
			case ({accept, pop})
				2'b10:   reserved_q <= reserved_q + QCNT_W'(1);
				2'b01:   reserved_q <= reserved_q - QCNT_W'(1);
				default: reserved_q <= reserved_q;
			endcase
		end
	end

	rtpfu_ts90k u_ts (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (accept),
		.in_item   (norm),
		.base_ts   (base_ts),
		.out_vld   (push),
		.out_entry (push_entry)
	);

	a_reserved_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reserved_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("slot count above queue depth");

endmodule

>>> design/rtpfu_fifo.sv
module rtpfu_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rtpfu_pkg::q_entry_t push_entry,
	input  logic                pop,
	output logic                head_valid,
	output rtpfu_pkg::q_entry_t head
);
	import rtpfu_pkg::*;

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && count_q == QCNT_W'(QUEUE_DEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && count_q == '0))
		else $error("queue read while empty");

endmodule

>>> design/rtpfu_back.sv
module rtpfu_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  rtpfu_pkg::q_entry_t  head,
	output logic                 pop,
	input  logic [10:0]          max_payload,
	input  rtpfu_pkg::seq_load_t seq_load,
	output logic                 pkt_valid,
	input  logic                 pkt_ready,
	output rtpfu_pkg::pkt_item_t pkt_data
);
	import rtpfu_pkg::*;

	typedef enum logic [1:0] {
		RK_IND  = 2'd0,
		RK_FUH  = 2'd1,
		RK_DATA = 2'd2
	} res_kind_e;

	logic [15:0] pos_q, pos_d;
	logic [10:0] fill_q, fill_d;
	logic [7:0]  hdr_q;
	logic [31:0] ts_q;
	logic [15:0] rtp_q, tseq_q;
	logic [1:0]  cnt_q;
	logic        pkt_valid_q;
	pkt_item_t   pkt_q, pkt_d;

	logic        whole, last_byte, final_frag, pkt_last_frag, adv_seq;
	logic [10:0] chunk, room;
	logic [1:0]  nres;
	logic        last_res, load, done;
	res_kind_e   kind;
	logic [31:0] ts_use;
	logic [15:0] len;

	assign len        = head.item.nal_length;
	assign whole      = len <= 16'(max_payload);
	assign last_byte  = (17'(pos_q) + 17'd1) >= 17'(len);
	assign chunk      = (max_payload < 11'd3) ? 11'd1 : max_payload - 11'd2;
	assign room       = (fill_q < chunk) ? chunk - fill_q : 11'd1;
	assign final_frag = (17'(pos_q) + 17'(room)) >= 17'(len);
	assign pkt_last_frag = last_byte || ((12'(fill_q) + 12'd1) >= 12'(chunk));
	assign ts_use     = (pos_q == 16'd0) ? head.ts : ts_q;

	// A fragmented unit's header byte gives nothing; the first byte of each
	// fragment is preceded by the FU indicator and FU header.
	always_comb begin
		if (whole) begin
			nres = 2'd1;
		end else if (pos_q == 16'd0) begin
			nres = 2'd0;
		end else if (fill_q == 11'd0) begin
			nres = 2'd3;
		end else begin
			nres = 2'd1;
		end
	end

	always_comb begin
		kind = RK_DATA;
		if (nres == 2'd3) begin
			case (cnt_q)
				2'd0:    kind = RK_IND;
				2'd1:    kind = RK_FUH;
				default: kind = RK_DATA;
			endcase
		end
	end

	assign last_res = cnt_q == (nres - 2'd1);
	assign load     = head_valid && (nres != 2'd0) && (!pkt_valid_q || pkt_ready);
	assign done     = head_valid && ((nres == 2'd0) || (load && last_res));
	assign pop      = done;

	always_comb begin
		pkt_d.out_byte         = head.item.nal_byte;
		pkt_d.packet_first     = 1'b0;
		pkt_d.packet_last      = 1'b0;
		pkt_d.run_last         = last_res;
		pkt_d.marker_bit       = head.item.unit_last_nal;
		pkt_d.rtp_seq          = rtp_q;
		pkt_d.transport_seq    = tseq_q;
		pkt_d.stamp_90k        = ts_use;
		pkt_d.capture_time_out = head.item.capture_us;
		pkt_d.frame_kind_out   = head.item.frame_kind;
		pkt_d.end_hint         = END_HINT_VAL;
		if (whole) begin
			pkt_d.packet_first = pos_q == 16'd0;
			pkt_d.packet_last  = last_byte;
		end else begin
			pkt_d.marker_bit = head.item.unit_last_nal && final_frag;
			pkt_d.end_hint   = final_frag ? END_HINT_VAL : 6'd0;
			case (kind)
				RK_IND: begin
					pkt_d.out_byte     = (hdr_q & NRI_MASK) | FU_A_TYPE;
					pkt_d.packet_first = 1'b1;
				end
				RK_FUH: begin
					pkt_d.out_byte = ((pos_q == 16'd1) ? FU_START : 8'd0) |
						(final_frag ? FU_END : 8'd0) | (hdr_q & TYPE_MASK);
				end
				default: begin
					pkt_d.packet_last = pkt_last_frag;
				end
			endcase
		end
	end

	always_comb begin
		adv_seq = 1'b0;
		fill_d  = 11'd0;
		pos_d   = last_byte ? 16'd0 : pos_q + 16'd1;
		if (whole) begin
			adv_seq = last_byte;
		end else if (pos_q != 16'd0) begin
			adv_seq = pkt_last_frag;
			fill_d  = pkt_last_frag ? 11'd0 : fill_q + 11'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			fill_q      <= '0;
			hdr_q       <= '0;
			ts_q        <= '0;
			rtp_q       <= '0;
			tseq_q      <= '0;
			cnt_q       <= '0;
			pkt_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pkt_valid_q <= 1'b1;
				cnt_q       <= last_res ? 2'd0 : cnt_q + 2'd1;
			end else if (pkt_ready) begin
				pkt_valid_q <= 1'b0;
			end
			if (done) begin
				pos_q  <= pos_d;
				fill_q <= fill_d;
				if (pos_q == 16'd0) begin
					ts_q  <= head.ts;
					hdr_q <= head.item.nal_byte;
				end
				if (adv_seq) begin
					rtp_q  <= rtp_q + 16'd1;
					tseq_q <= tseq_q + 16'd1;
				end
			end
			if (seq_load.rtp_ld) begin
				rtp_q <= seq_load.value;
			end
			if (seq_load.tseq_ld) begin
				tseq_q <= seq_load.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pkt_q <= pkt_d;
		end
	end

	assign pkt_valid = pkt_valid_q;
	assign pkt_data  = pkt_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result counter out of range");

	a_cnt_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_res) |=> (cnt_q == 2'd0))
		else $error("result counter not cleared after last result");

endmodule

>>> design/h264_rtp_fua_packetizer.sv
// Channel  | Handshake             | Payload                | Moves
// nal      | nal_valid / nal_ready | nal_data (nal_item_t)  | one NAL byte in
// pkt      | pkt_valid / pkt_ready | pkt_data (pkt_item_t)  | one payload byte out
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data    | one register write
//
// One NAL byte per cycle while nal_ready is high; the first byte of each FU-A fragment
// gives three results on the output side (indicator, FU header, byte), and a fragmented
// unit's header byte is taken with no output. The 90 kHz timestamp divider is a 12-stage
// pipeline; a byte then passes through the queue and the packet engine's output register.
// A 16-entry queue separates the divider from the packet engine; nal_ready drops
// only when all 16 slots are held. Reset is asynchronous; cfg_ready is always high.
module h264_rtp_fua_packetizer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 nal_valid,
	output logic                 nal_ready,
	input  rtpfu_pkg::nal_item_t nal_data,
	output logic                 pkt_valid,
	input  logic                 pkt_ready,
	output rtpfu_pkg::pkt_item_t pkt_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import rtpfu_pkg::*;

	logic [10:0] max_payload_q;
	logic [31:0] base_ts_q;
	logic        cfg_wr;
	seq_load_t   seq_load;

	logic        push, pop, head_valid;
	q_entry_t    push_entry, head;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// The sequence start values go straight into the counters. Payload type and
	// SSRC do not shape the byte stream, so their writes are taken and dropped.
	assign seq_load.rtp_ld  = cfg_wr && (cfg_index == CFG_FIRST_RTP_SEQ);
	assign seq_load.tseq_ld = cfg_wr && (cfg_index == CFG_FIRST_TSEQ);
	assign seq_load.value   = cfg_data[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			base_ts_q     <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_reg_e'(cfg_index))
				CFG_MAX_PAYLOAD: max_payload_q <= cfg_data[10:0];
				CFG_BASE_TS:     base_ts_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rtpfu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.nal_valid  (nal_valid),
		.nal_ready  (nal_ready),
		.nal_data   (nal_data),
		.pop        (pop),
		.base_ts    (base_ts_q),
		.push       (push),
		.push_entry (push_entry)
	);

	rtpfu_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	rtpfu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.max_payload (max_payload_q),
		.seq_load    (seq_load),
		.pkt_valid   (pkt_valid),
		.pkt_ready   (pkt_ready),
		.pkt_data    (pkt_data)
	);

endmodule
